@@ rtl/etcb_pkg.sv @@
// Shared types, register codes and the colormap table of the event-time colormap blender.
`timescale 1ns / 1ps

package etcb_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CMAP_LEN  = 64;
    localparam int CMAP_IDXW = 6;
    localparam logic [CMAP_IDXW-1:0] CMAP_LAST = 6'd63;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_TIME   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_SCALE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ALPHA  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_COLOR   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

    localparam logic [63:0] RST_BEGIN_TIME   = 64'd0;
    localparam logic [30:0] RST_TIME_SCALE   = 31'd1073741824;
    localparam logic [16:0] RST_BLEND_ALPHA  = 17'd6554;
    localparam logic [23:0] RST_IDLE_COLOR   = 24'd2697513;
    localparam logic [9:0]  RST_FRAME_WIDTH  = 10'd304;
    localparam logic [8:0]  RST_FRAME_HEIGHT = 9'd240;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [1:0] KIND_BLEND = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  pos_x;
        logic [7:0]  pos_y;
        logic [63:0] timestamp;
    } item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    function automatic logic [23:0] cmap_color(input logic [CMAP_IDXW-1:0] idx);
        logic [23:0] c;
        case (idx)
            6'd0:  c = {8'd53,  8'd42,  8'd135};
            6'd1:  c = {8'd54,  8'd48,  8'd147};
            6'd2:  c = {8'd54,  8'd55,  8'd160};
            6'd3:  c = {8'd53,  8'd61,  8'd173};
            6'd4:  c = {8'd50,  8'd67,  8'd186};
            6'd5:  c = {8'd44,  8'd74,  8'd199};
            6'd6:  c = {8'd32,  8'd83,  8'd212};
            6'd7:  c = {8'd15,  8'd92,  8'd221};
            6'd8:  c = {8'd3,   8'd99,  8'd225};
            6'd9:  c = {8'd2,   8'd104, 8'd225};
            6'd10: c = {8'd4,   8'd109, 8'd224};
            6'd11: c = {8'd8,   8'd113, 8'd222};
            6'd12: c = {8'd13,  8'd117, 8'd220};
            6'd13: c = {8'd16,  8'd121, 8'd218};
            6'd14: c = {8'd18,  8'd125, 8'd216};
            6'd15: c = {8'd20,  8'd129, 8'd214};
            6'd16: c = {8'd20,  8'd133, 8'd212};
            6'd17: c = {8'd19,  8'd137, 8'd211};
            6'd18: c = {8'd16,  8'd142, 8'd210};
            6'd19: c = {8'd12,  8'd147, 8'd210};
            6'd20: c = {8'd9,   8'd152, 8'd209};
            6'd21: c = {8'd7,   8'd156, 8'd207};
            6'd22: c = {8'd6,   8'd160, 8'd205};
            6'd23: c = {8'd6,   8'd164, 8'd202};
            6'd24: c = {8'd6,   8'd167, 8'd198};
            6'd25: c = {8'd7,   8'd169, 8'd194};
            6'd26: c = {8'd10,  8'd172, 8'd190};
            6'd27: c = {8'd15,  8'd174, 8'd185};
            6'd28: c = {8'd21,  8'd177, 8'd180};
            6'd29: c = {8'd29,  8'd179, 8'd175};
            6'd30: c = {8'd37,  8'd181, 8'd169};
            6'd31: c = {8'd46,  8'd183, 8'd164};
            6'd32: c = {8'd56,  8'd185, 8'd158};
            6'd33: c = {8'd66,  8'd187, 8'd152};
            6'd34: c = {8'd77,  8'd188, 8'd146};
            6'd35: c = {8'd89,  8'd189, 8'd140};
            6'd36: c = {8'd101, 8'd190, 8'd134};
            6'd37: c = {8'd113, 8'd191, 8'd128};
            6'd38: c = {8'd124, 8'd191, 8'd123};
            6'd39: c = {8'd135, 8'd191, 8'd119};
            6'd40: c = {8'd146, 8'd191, 8'd115};
            6'd41: c = {8'd156, 8'd191, 8'd111};
            6'd42: c = {8'd165, 8'd190, 8'd107};
            6'd43: c = {8'd174, 8'd190, 8'd103};
            6'd44: c = {8'd183, 8'd189, 8'd100};
            6'd45: c = {8'd192, 8'd188, 8'd96};
            6'd46: c = {8'd200, 8'd188, 8'd93};
            6'd47: c = {8'd209, 8'd187, 8'd89};
            6'd48: c = {8'd217, 8'd186, 8'd86};
            6'd49: c = {8'd225, 8'd185, 8'd82};
            6'd50: c = {8'd233, 8'd185, 8'd78};
            6'd51: c = {8'd241, 8'd185, 8'd74};
            6'd52: c = {8'd248, 8'd187, 8'd68};
            6'd53: c = {8'd253, 8'd190, 8'd61};
            6'd54: c = {8'd255, 8'd195, 8'd55};
            6'd55: c = {8'd254, 8'd200, 8'd50};
            6'd56: c = {8'd252, 8'd206, 8'd46};
            6'd57: c = {8'd250, 8'd211, 8'd42};
            6'd58: c = {8'd247, 8'd216, 8'd38};
            6'd59: c = {8'd245, 8'd222, 8'd33};
            6'd60: c = {8'd245, 8'd228, 8'd29};
            6'd61: c = {8'd245, 8'd235, 8'd24};
            6'd62: c = {8'd246, 8'd243, 8'd19};
            6'd63: c = {8'd249, 8'd251, 8'd14};
            default: c = {8'd249, 8'd251, 8'd14};
        endcase
        return c;
    endfunction

endpackage

@@ rtl/etcb_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module etcb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = etcb_pkg::DEF_MAX_WIDTH * etcb_pkg::DEF_MAX_HEIGHT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             wr,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/event_time_colormap_blender.sv @@
// Top level: event-time colormap blender with a frame store in one RAM.
// A blend goes through address calculation, store read, data capture, interpolation and
// its write; a clear through address calculation and its write; a read returns the stored
// pixel, held while an earlier result sits stalled; an item outside the frame is dropped
// after address calculation. The sequencer handles one item at a time on one store port.
// Reset: control state clears and the registers take their reset values; the frame store
// is not cleared, so a pixel must be cleared before it is read or blended.
`timescale 1ns / 1ps

module event_time_colormap_blender #(
    parameter int MAX_WIDTH  = etcb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = etcb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  etcb_pkg::item_t                    in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output etcb_pkg::pixel_t                   out_data,
    input  logic                               cfg_write,
    input  logic [etcb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [etcb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int LW    = HW + WW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CALC   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_DATA   = 3'd3;
    localparam logic [2:0] S_INTERP = 3'd4;
    localparam logic [2:0] S_BLEND  = 3'd5;
    localparam logic [2:0] S_WRITE  = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [2:0] state_reg, state_next;

    logic [63:0] begin_time_reg;
    logic [30:0] time_scale_reg;
    logic [16:0] blend_alpha_reg;
    logic [23:0] idle_color_reg;
    logic [9:0]  frame_width_reg;
    logic [8:0]  frame_height_reg;

    etcb_pkg::item_t  item_reg;
    logic [AW-1:0]    addr_reg;
    logic [31:0]      diff_lo_reg;
    logic             last_reg;
    logic [62:0]      prod_reg;
    logic [23:0]      old_reg;
    logic [5:0]       idx_reg;
    logic [15:0]      frac_reg;
    logic [23:0]      c0_reg;
    logic [23:0]      c1_reg;
    logic [23:0]      color_reg;

    logic             out_valid_reg, out_valid_next;
    etcb_pkg::pixel_t out_data_reg;

    logic             accept;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic             hit;
    logic [HW-1:0]    row;
    logic [LW-1:0]    lin;
    logic [AW-1:0]    addr_next;
    logic [64:0]      diff_full;
    logic             early;
    logic             far;
    logic [38:0]      ip;
    logic             sel_last;
    logic [5:0]       idx_next;
    logic [5:0]       idx_up;
    logic [15:0]      frac_next;
    logic [23:0]      color_next;
    logic [23:0]      blend_out;
    logic [16:0]      alpha_eff;

    logic             ram_en;
    logic             ram_wr;
    logic [23:0]      ram_wdata;
    logic [23:0]      ram_rdata;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_time_reg   <= etcb_pkg::RST_BEGIN_TIME;
            time_scale_reg   <= etcb_pkg::RST_TIME_SCALE;
            blend_alpha_reg  <= etcb_pkg::RST_BLEND_ALPHA;
            idle_color_reg   <= etcb_pkg::RST_IDLE_COLOR;
            frame_width_reg  <= etcb_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= etcb_pkg::RST_FRAME_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                etcb_pkg::REG_BEGIN_TIME:   begin_time_reg   <= cfg_data;
                etcb_pkg::REG_TIME_SCALE:   time_scale_reg   <= cfg_data[30:0];
                etcb_pkg::REG_BLEND_ALPHA:  blend_alpha_reg  <= cfg_data[16:0];
                etcb_pkg::REG_IDLE_COLOR:   idle_color_reg   <= cfg_data[23:0];
                etcb_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[9:0];
                etcb_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // frame geometry and pixel address
    always_comb
    begin
        w_eff = (32'(frame_width_reg) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(frame_width_reg);
        h_eff = (32'(frame_height_reg) > 32'(MAX_HEIGHT)) ?
                HW'(MAX_HEIGHT) : HW'(frame_height_reg);
        hit   = (item_reg.kind != etcb_pkg::KIND_NONE) &&
                (32'(item_reg.pos_x) < 32'(w_eff)) &&
                (32'(item_reg.pos_y) < 32'(h_eff));
        row   = HW'(32'(h_eff) - 32'd1 - 32'(item_reg.pos_y));
        lin   = LW'(row) * LW'(w_eff);
        addr_next = AW'(lin + LW'(item_reg.pos_x));
    end

    // time offset; an early time or one beyond 32 bits with nonzero scale hits the last entry
    assign diff_full = {1'b0, item_reg.timestamp} - {1'b0, begin_time_reg};
    assign early     = diff_full[64];
    assign far       = (diff_full[63:32] != 32'd0) && (time_scale_reg != 31'd0);

    // colormap index and fraction
    always_comb
    begin
        ip        = prod_reg[62:24];
        sel_last  = last_reg || (ip >= 39'(etcb_pkg::CMAP_LAST));
        idx_next  = sel_last ? etcb_pkg::CMAP_LAST : ip[5:0];
        frac_next = sel_last ? 16'd0 : prod_reg[23:8];
        idx_up    = (idx_next == etcb_pkg::CMAP_LAST) ? idx_next : idx_next + 6'd1;
    end

    // interpolate between neighboring entries, truncating
    always_comb
    begin
        logic [16:0] inv_frac;
        logic [23:0] mix;
        inv_frac   = etcb_pkg::ONE_Q16 - 17'(frac_reg);
        color_next = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            mix = 24'(c1_reg[8*ch +: 8]) * 24'(frac_reg) +
                  24'(c0_reg[8*ch +: 8]) * 24'(inv_frac);
            color_next[8*ch +: 8] = mix[23:16];
        end
    end

    // alpha blend into the stored pixel, truncating
    always_comb
    begin
        logic [16:0] inv_alpha;
        logic [23:0] mix;
        alpha_eff = (blend_alpha_reg > etcb_pkg::ONE_Q16) ? etcb_pkg::ONE_Q16 : blend_alpha_reg;
        inv_alpha = etcb_pkg::ONE_Q16 - alpha_eff;
        blend_out = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            mix = 24'(old_reg[8*ch +: 8]) * 24'(inv_alpha) +
                  24'(color_reg[8*ch +: 8]) * 24'(alpha_eff);
            blend_out[8*ch +: 8] = mix[23:16];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (!hit)
                begin
                    state_next = S_IDLE;
                end
                else if (item_reg.kind == etcb_pkg::KIND_CLEAR)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:   state_next = S_DATA;
            S_DATA:   state_next = (item_reg.kind == etcb_pkg::KIND_READ) ? S_RESP : S_INTERP;
            S_INTERP: state_next = S_BLEND;
            S_BLEND:  state_next = S_IDLE;
            S_WRITE:  state_next = S_IDLE;
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_CALC)
        begin
            addr_reg    <= addr_next;
            diff_lo_reg <= diff_full[31:0];
            last_reg    <= early || far;
        end
        if (state_reg == S_READ)
        begin
            prod_reg <= 63'(diff_lo_reg) * 63'(time_scale_reg);
        end
        if (state_reg == S_DATA)
        begin
            old_reg  <= ram_rdata;
            idx_reg  <= idx_next;
            frac_reg <= frac_next;
            c0_reg   <= etcb_pkg::cmap_color(idx_next);
            c1_reg   <= etcb_pkg::cmap_color(idx_up);
        end
        if (state_reg == S_INTERP)
        begin
            color_reg <= color_next;
        end
    end

    // frame store access
    assign ram_wr    = (state_reg == S_BLEND) || (state_reg == S_WRITE);
    assign ram_en    = ram_wr || (state_reg == S_READ);
    assign ram_wdata = (state_reg == S_BLEND) ? blend_out : idle_color_reg;

    etcb_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .wr    (ram_wr),
        .addr  (addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // output register: hold the read transaction until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_RESP && (!out_valid_reg || !out_stall))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RESP && (!out_valid_reg || !out_stall))
        begin
            out_data_reg <= old_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CALC))
        else $error("accepted transaction did not enter address calculation");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            ($past(state_reg) == S_RESP && item_reg.kind == etcb_pkg::KIND_READ))
        else $error("result appeared without a read transaction");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr |-> (item_reg.kind != etcb_pkg::KIND_READ && item_reg.kind != etcb_pkg::KIND_NONE))
        else $error("frame store written by a read or unknown transaction");

    a_last_entry_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INTERP && idx_reg == etcb_pkg::CMAP_LAST) |-> (frac_reg == 16'd0))
        else $error("last colormap entry interpolated with nonzero fraction");

endmodule

@@ bench/testbench.sv @@
// Testbench for the event-time colormap blender: directed table, then randomized phases.
`timescale 1ns / 1ps

module testbench;

    import etcb_pkg::*;

    localparam int STORE_DEPTH   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 232;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECK, ROW_REG} row_op_t;

    typedef struct {
        row_op_t     op;
        item_t       it;
        logic [2:0]  idx;
        logic [63:0] val;
        pixel_t      want;
    } row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    item_t       in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    pixel_t      out_data;
    logic        cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Register copies seen by the pixel predictor
    logic [63:0] cfg_begin  = RST_BEGIN_TIME;
    logic [30:0] cfg_scale  = RST_TIME_SCALE;
    logic [16:0] cfg_alpha  = RST_BLEND_ALPHA;
    logic [23:0] cfg_idle   = RST_IDLE_COLOR;
    logic [9:0]  cfg_width  = RST_FRAME_WIDTH;
    logic [8:0]  cfg_height = RST_FRAME_HEIGHT;

    logic [23:0] frame_mem [STORE_DEPTH];
    bit          frame_set [STORE_DEPTH];
    pixel_t      reads_due [$];
    row_t        plan [$];

    int          fails = 0;
    int          cycles;
    int          stall_left = 0;
    bit          quiet = 1'b0;

    logic [23:0] palette [64] = '{
        {8'd53, 8'd42, 8'd135},   {8'd54, 8'd48, 8'd147},   {8'd54, 8'd55, 8'd160},
        {8'd53, 8'd61, 8'd173},   {8'd50, 8'd67, 8'd186},   {8'd44, 8'd74, 8'd199},
        {8'd32, 8'd83, 8'd212},   {8'd15, 8'd92, 8'd221},   {8'd3, 8'd99, 8'd225},
        {8'd2, 8'd104, 8'd225},   {8'd4, 8'd109, 8'd224},   {8'd8, 8'd113, 8'd222},
        {8'd13, 8'd117, 8'd220},  {8'd16, 8'd121, 8'd218},  {8'd18, 8'd125, 8'd216},
        {8'd20, 8'd129, 8'd214},  {8'd20, 8'd133, 8'd212},  {8'd19, 8'd137, 8'd211},
        {8'd16, 8'd142, 8'd210},  {8'd12, 8'd147, 8'd210},  {8'd9, 8'd152, 8'd209},
        {8'd7, 8'd156, 8'd207},   {8'd6, 8'd160, 8'd205},   {8'd6, 8'd164, 8'd202},
        {8'd6, 8'd167, 8'd198},   {8'd7, 8'd169, 8'd194},   {8'd10, 8'd172, 8'd190},
        {8'd15, 8'd174, 8'd185},  {8'd21, 8'd177, 8'd180},  {8'd29, 8'd179, 8'd175},
        {8'd37, 8'd181, 8'd169},  {8'd46, 8'd183, 8'd164},  {8'd56, 8'd185, 8'd158},
        {8'd66, 8'd187, 8'd152},  {8'd77, 8'd188, 8'd146},  {8'd89, 8'd189, 8'd140},
        {8'd101, 8'd190, 8'd134}, {8'd113, 8'd191, 8'd128}, {8'd124, 8'd191, 8'd123},
        {8'd135, 8'd191, 8'd119}, {8'd146, 8'd191, 8'd115}, {8'd156, 8'd191, 8'd111},
        {8'd165, 8'd190, 8'd107}, {8'd174, 8'd190, 8'd103}, {8'd183, 8'd189, 8'd100},
        {8'd192, 8'd188, 8'd96},  {8'd200, 8'd188, 8'd93},  {8'd209, 8'd187, 8'd89},
        {8'd217, 8'd186, 8'd86},  {8'd225, 8'd185, 8'd82},  {8'd233, 8'd185, 8'd78},
        {8'd241, 8'd185, 8'd74},  {8'd248, 8'd187, 8'd68},  {8'd253, 8'd190, 8'd61},
        {8'd255, 8'd195, 8'd55},  {8'd254, 8'd200, 8'd50},  {8'd252, 8'd206, 8'd46},
        {8'd250, 8'd211, 8'd42},  {8'd247, 8'd216, 8'd38},  {8'd245, 8'd222, 8'd33},
        {8'd245, 8'd228, 8'd29},  {8'd245, 8'd235, 8'd24},  {8'd246, 8'd243, 8'd19},
        {8'd249, 8'd251, 8'd14}
    };

    event_time_colormap_blender u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int frame_w();
        return (cfg_width > 10'(DEF_MAX_WIDTH)) ? DEF_MAX_WIDTH : int'(cfg_width);
    endfunction

    function automatic int frame_h();
        return (cfg_height > 9'(DEF_MAX_HEIGHT)) ? DEF_MAX_HEIGHT : int'(cfg_height);
    endfunction

    // Store address of a pixel, or -1 when it lies outside the active frame
    function automatic int pixel_addr(input logic [8:0] x, input logic [7:0] y);
        int w;
        int h;
        w = frame_w();
        h = frame_h();
        if (int'(x) >= w || int'(y) >= h)
            return -1;
        return int'(x) + (h - 1 - int'(y)) * w;
    endfunction

    function automatic logic [23:0] time_color(input logic [63:0] t);
        logic [63:0] diff;
        logic [63:0] prod;
        logic [5:0]  idx;
        int unsigned frac;
        int unsigned c0;
        int unsigned c1;
        int unsigned v;
        logic [23:0] rgb;
        if (t < cfg_begin)
            return palette[63];
        diff = t - cfg_begin;
        if (cfg_scale == '0)
        begin
            idx = '0;
            frac = 0;
        end
        else if (diff[63:32] != '0)
            return palette[63];
        else
        begin
            prod = {32'd0, diff[31:0]} * {33'd0, cfg_scale};
            if (prod[63:24] >= 40'd63)
                return palette[63];
            idx = prod[29:24];
            frac = prod[23:8];
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            c0 = palette[idx][8*ch +: 8];
            c1 = palette[idx + 1][8*ch +: 8];
            v = (c1 * frac + c0 * (65536 - frac)) >> 16;
            rgb[8*ch +: 8] = v[7:0];
        end
        return rgb;
    endfunction

    function automatic logic [23:0] blend_color(input logic [23:0] old, input logic [23:0] col);
        int unsigned a;
        int unsigned o;
        int unsigned c;
        int unsigned v;
        logic [23:0] res;
        a = (cfg_alpha > ONE_Q16) ? 65536 : cfg_alpha;
        for (int ch = 0; ch < 3; ch++)
        begin
            o = old[8*ch +: 8];
            c = col[8*ch +: 8];
            v = (o * (65536 - a) + c * a) >> 16;
            res[8*ch +: 8] = v[7:0];
        end
        return res;
    endfunction

    // Update the frame copy for one accepted transaction; return 1 when a pixel comes back
    function automatic bit apply_item(input item_t it, output pixel_t px);
        int a;
        px = '0;
        a = pixel_addr(it.pos_x, it.pos_y);
        if (it.kind == KIND_NONE || a < 0)
            return 1'b0;
        case (it.kind)
            KIND_BLEND: frame_mem[a] = blend_color(frame_mem[a], time_color(it.timestamp));
            KIND_CLEAR:
            begin
                frame_mem[a] = cfg_idle;
                frame_set[a] = 1'b1;
            end
            default:
            begin
                px = frame_mem[a];
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic item_t pick_item();
        item_t       it;
        int          w;
        int          h;
        int          hw;
        int          hh;
        int          r;
        int          a;
        logic [63:0] span;
        w = frame_w();
        h = frame_h();
        hw = (w < 4) ? w : 4;
        hh = (h < 4) ? h : 4;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            it.pos_x = 9'($urandom);
            it.pos_y = 8'($urandom);
        end
        else if (r < 40)
        begin
            it.pos_x = 9'($urandom_range(0, w - 1));
            it.pos_y = 8'($urandom_range(0, h - 1));
        end
        else
        begin
            // Keep hitting a few corner pixels so blends and reads land on live data
            it.pos_x = 9'($urandom_range(0, 1) ? $urandom_range(0, hw - 1)
                                               : w - 1 - $urandom_range(0, hw - 1));
            it.pos_y = 8'($urandom_range(0, 1) ? $urandom_range(0, hh - 1)
                                               : h - 1 - $urandom_range(0, hh - 1));
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            it.kind = KIND_NONE;
        else if (r < 20)
            it.kind = KIND_CLEAR;
        else if (r < 62)
            it.kind = KIND_BLEND;
        else
            it.kind = KIND_READ;
        span = (cfg_scale == '0) ? 64'd100000 : (64'd1 << 30) / cfg_scale;
        r = $urandom_range(0, 9);
        if (r == 0)
            it.timestamp = {$urandom, $urandom};
        else if (r == 1)
            it.timestamp = cfg_begin - $urandom_range(1, 32'(span) + 1);
        else
            it.timestamp = cfg_begin + $urandom_range(0, 32'(span + span / 8));
        a = pixel_addr(it.pos_x, it.pos_y);
        if (a >= 0 && (it.kind == KIND_BLEND || it.kind == KIND_READ) && !frame_set[a])
            it.kind = KIND_CLEAR;
        return it;
    endfunction

    function automatic row_t item_row(input logic [1:0] k, input int x, input int y,
                                      input logic [63:0] t);
        row_t r;
        r.op = ROW_ITEM;
        r.it.kind = k;
        r.it.pos_x = 9'(x);
        r.it.pos_y = 8'(y);
        r.it.timestamp = t;
        r.idx = '0;
        r.val = '0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t check_row(input int x, input int y, input logic [23:0] want);
        row_t r;
        r = item_row(KIND_READ, x, y, 64'd0);
        r.op = ROW_CHECK;
        r.want = want;
        return r;
    endfunction

    function automatic row_t reg_row(input logic [2:0] idx, input logic [63:0] val);
        row_t r;
        r = item_row(KIND_NONE, 0, 0, 64'd0);
        r.op = ROW_REG;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    task automatic send_item(input item_t it, input bit typed, input pixel_t want);
        bit     gives;
        pixel_t px;
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gives = apply_item(it, px);
        if (gives)
            reads_due.push_back(typed ? want : px);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Hold off until every read is back and the last write has landed
    task automatic settle();
        in_valid <= 1'b0;
        while (reads_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [63:0] val);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_BEGIN_TIME:   cfg_begin = val;
            REG_TIME_SCALE:   cfg_scale = val[30:0];
            REG_BLEND_ALPHA:  cfg_alpha = val[16:0];
            REG_IDLE_COLOR:   cfg_idle = val[23:0];
            REG_FRAME_WIDTH:  cfg_width = val[9:0];
            REG_FRAME_HEIGHT: cfg_height = val[8:0];
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        fails++;
        $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    // Receiver stalls in random bursts until the quiet stretch
    always @(posedge clk)
    begin
        if (quiet)
        begin
            stall_left <= 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_reads
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reads_due.size() == 0)
            begin
                fails++;
                $display("%0t ns: expected nothing, actual pixel %h", $time, out_data);
            end
            else
            begin
                want = reads_due.pop_front();
                if (want.red !== out_data.red)
                    note_mismatch("red", want.red, out_data.red);
                if (want.green !== out_data.green)
                    note_mismatch("green", want.green, out_data.green);
                if (want.blue !== out_data.blue)
                    note_mismatch("blue", want.blue, out_data.blue);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        item_t       it;
        int          done;
        int          k;
        int          w;
        int          h;
        logic [63:0] b;
        logic [30:0] s;
        logic [16:0] a;
        logic [23:0] idle;

        // Reset state first, then corners, out-of-frame drops and register extremes
        plan.push_back(item_row(KIND_CLEAR, 0, 0, 64'd0));
        plan.push_back(check_row(0, 0, 24'h292929));
        plan.push_back(item_row(KIND_CLEAR, 303, 239, 64'd0));
        plan.push_back(check_row(303, 239, 24'h292929));
        plan.push_back(item_row(KIND_BLEND, 0, 0, 64'd0));
        plan.push_back(item_row(KIND_READ, 0, 0, 64'd0));
        plan.push_back(item_row(KIND_BLEND, 303, 239, '1));
        plan.push_back(item_row(KIND_READ, 303, 239, 64'd0));
        plan.push_back(item_row(KIND_CLEAR, 304, 0, 64'd0));
        plan.push_back(item_row(KIND_READ, 0, 240, 64'd0));
        plan.push_back(item_row(KIND_NONE, 0, 0, '1));
        plan.push_back(item_row(KIND_READ, 0, 0, 64'd0));
        plan.push_back(reg_row(REG_BEGIN_TIME, 64'd1000));
        plan.push_back(reg_row(REG_TIME_SCALE, 64'd1 << 23));
        plan.push_back(reg_row(REG_BLEND_ALPHA, 64'(ONE_Q16)));
        plan.push_back(item_row(KIND_BLEND, 0, 0, 64'd999));
        plan.push_back(check_row(0, 0, 24'hF9FB0E));
        plan.push_back(item_row(KIND_BLEND, 0, 0, 64'd1125));
        plan.push_back(item_row(KIND_READ, 0, 0, 64'd0));
        plan.push_back(item_row(KIND_BLEND, 0, 0, 64'd1126));
        plan.push_back(check_row(0, 0, 24'hF9FB0E));
        plan.push_back(reg_row(REG_TIME_SCALE, 64'd0));
        plan.push_back(reg_row(REG_BLEND_ALPHA, 64'h1FFFF));
        plan.push_back(item_row(KIND_BLEND, 303, 239, '1));
        plan.push_back(check_row(303, 239, 24'h352A87));
        plan.push_back(reg_row(REG_BLEND_ALPHA, 64'd0));
        plan.push_back(item_row(KIND_BLEND, 303, 239, 64'd5000));
        plan.push_back(check_row(303, 239, 24'h352A87));
        plan.push_back(reg_row(REG_IDLE_COLOR, 64'hFFFFFF));
        plan.push_back(reg_row(REG_FRAME_WIDTH, 64'd1023));
        plan.push_back(reg_row(REG_FRAME_HEIGHT, 64'd511));
        plan.push_back(item_row(KIND_CLEAR, 511, 255, 64'd0));
        plan.push_back(check_row(511, 255, 24'hFFFFFF));
        plan.push_back(reg_row(REG_FRAME_WIDTH, 64'd0));
        plan.push_back(item_row(KIND_CLEAR, 0, 0, 64'd0));
        plan.push_back(item_row(KIND_READ, 0, 0, 64'd0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            case (plan[i].op)
                ROW_ITEM:  send_item(plan[i].it, 1'b0, '0);
                ROW_CHECK: send_item(plan[i].it, 1'b1, plan[i].want);
                default:   set_reg(plan[i].idx, plan[i].val);
            endcase
        end

        for (int p = 0; p < PHASES; p++)
        begin
            k = $urandom_range(0, 30);
            b = {$urandom, $urandom};
            s = (31'd1 << k) | 31'($urandom_range(0, (1 << k) - 1));
            a = 17'($urandom_range(1, 65536));
            idle = 24'($urandom);
            w = $urandom_range(1, DEF_MAX_WIDTH);
            h = $urandom_range(1, DEF_MAX_HEIGHT);
            case (p)
                0:
                begin
                    b = '0;
                    s = 31'd1 << 16;
                    a = RST_BLEND_ALPHA;
                    w = 304;
                    h = 240;
                end
                2:
                begin
                    w = $urandom_range(1, 4);
                    h = $urandom_range(1, 3);
                    a = ONE_Q16;
                end
                3:
                begin
                    b = '1;
                    s = '1;
                    a = 17'($urandom_range(65537, 131071));
                    w = DEF_MAX_WIDTH;
                    h = DEF_MAX_HEIGHT;
                end
                4:
                begin
                    s = '0;
                    a = 17'd1;
                    w = 1023;
                    h = 511;
                end
                PHASES - 1:
                begin
                    w = 304;
                    h = 240;
                    quiet = 1'b1;
                end
                default: ;
            endcase
            set_reg(REG_BEGIN_TIME, b);
            set_reg(REG_TIME_SCALE, 64'(s));
            set_reg(REG_BLEND_ALPHA, 64'(a));
            set_reg(REG_IDLE_COLOR, 64'(idle));
            set_reg(REG_FRAME_WIDTH, 64'(w));
            set_reg(REG_FRAME_HEIGHT, 64'(h));
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                it = pick_item();
                done++;
                send_item(it, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (reads_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ event_time_colormap_blender.f @@
rtl/etcb_pkg.sv
rtl/etcb_ram.sv
rtl/event_time_colormap_blender.sv
bench/testbench.sv
